/* sv/pidsl_pkg.sv */
// Shared types, constants and saturation functions for the filtered-derivative PID speed loop.
`default_nettype none

package pidsl_pkg;

    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int GAIN_W    = 32;
    localparam int TERM_W    = 32;
    localparam int SMOOTH_W  = 16;
    localparam int DBAND_W   = 15;
    localparam int DRIVE_W   = 16;
    localparam int MPLR_W    = 18;
    localparam int MCAND_W   = 33;
    localparam int PROD_W    = MPLR_W + MCAND_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_SMOOTHING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND        = 3'd4;

    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'hFFFF;
    localparam logic [DBAND_W-1:0]  DBAND_RESET  = 15'd20;

    localparam logic signed [TERM_W-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic signed [SPEED_W-1:0] set_speed;
        logic signed [SPEED_W-1:0] measured_speed;
    } pidsl_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      in_deadband;
    } pidsl_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pidsl_mul_stat_t;

    // Product scaled by 2^14, held to the range [-2^31, 2^31] in 33 bits.
    function automatic logic signed [TERM_W:0] sat_shl14(input logic signed [PROD_W-1:0] p);
        logic signed [TERM_W:0] r;
        if (p > PROD_W'(131071))
        begin
            r = 33'sh0_8000_0000;
        end
        else if (p < -PROD_W'(131072))
        begin
            r = 33'sh1_8000_0000;
        end
        else
        begin
            r = {p[17], p[17:0], 14'b0};
        end
        return r;
    endfunction

    function automatic logic signed [TERM_W-1:0] sat32(input logic signed [TERM_W:0] x);
        logic signed [TERM_W-1:0] r;
        if (x > 33'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < 33'sh1_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[TERM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TERM_W-1:0] clamp_q30(input logic signed [TERM_W+1:0] x);
        logic signed [TERM_W-1:0] r;
        if (x > (TERM_W+2)'(ONE_Q30))
        begin
            r = ONE_Q30;
        end
        else if (x < -(TERM_W+2)'(ONE_Q30))
        begin
            r = -ONE_Q30;
        end
        else
        begin
            r = x[TERM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/pid_speed_loop_filtered_d.sv */
// Top level of the positional PID speed loop with filtered derivative and anti-windup.
//
// Input channel (in_valid, in_ready, in_data) takes one beat holding a target and a
// measured speed. Output channel (out_valid, out_ready, out_data) returns one beat per
// input beat: the Q1.15 drive and a flag that is set when the target lay inside the
// deadband and the previous drive was held. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes the gains, the derivative smoothing and the
// deadband; it is always ready and indices beyond the last register are ignored.
// An active beat needs four products from one shared bit-serial multiplier, each over
// its 18 multiplier bits plus a launch and a hand-over step, then a sum step and a
// rounding step; a new input beat is taken only once the last is through. A beat inside
// the deadband skips the products. The next beat is accepted while a finished result still
// waits in the output register; only if that register is still full when the following
// result is ready does the block wait for out_ready. Reset clears the integral, the
// previous error, the filter state and the held drive, and loads the register reset
// values; no output beat is pending after reset.
`default_nettype none

module pid_speed_loop_filtered_d
    import pidsl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pidsl_in_t             in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pidsl_out_t                 out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_P = 3'd1;
    localparam logic [2:0] S_MUL_I = 3'd2;
    localparam logic [2:0] S_MUL_D = 3'd3;
    localparam logic [2:0] S_MUL_F = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_DRIVE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        go_reg;
    logic                        go_next;

    logic signed [GAIN_W-1:0]    prop_reg;
    logic signed [GAIN_W-1:0]    integ_gain_reg;
    logic signed [GAIN_W-1:0]    deriv_reg;
    logic [SMOOTH_W-1:0]         smooth_reg;
    logic [DBAND_W-1:0]          dband_reg;

    logic signed [TERM_W-1:0]    integ_reg;
    logic signed [TERM_W-1:0]    integ_next;
    logic signed [ERR_W-1:0]     prev_reg;
    logic signed [ERR_W-1:0]     prev_next;
    logic signed [TERM_W-1:0]    f_reg;
    logic signed [TERM_W-1:0]    f_next;
    logic signed [DRIVE_W-1:0]   held_reg;
    logic signed [DRIVE_W-1:0]   held_next;

    logic signed [ERR_W-1:0]     err_reg;
    logic signed [ERR_W-1:0]     err_next;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [DIFF_W-1:0]    diff_next;
    logic signed [TERM_W-1:0]    p_reg;
    logic signed [TERM_W-1:0]    p_next;
    logic signed [TERM_W-1:0]    dr_reg;
    logic signed [TERM_W-1:0]    dr_next;
    logic signed [TERM_W-1:0]    sum_reg;
    logic signed [TERM_W-1:0]    sum_next;
    pidsl_out_t                  res_reg;
    pidsl_out_t                  res_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    pidsl_out_t                  out_data_reg;
    pidsl_out_t                  out_data_next;

    logic                        in_take;
    logic [ERR_W-1:0]            mag;
    logic                        in_dead;
    logic signed [ERR_W-1:0]     set_ext;

    logic signed [MPLR_W-1:0]    mul_mplr;
    logic signed [MCAND_W-1:0]   mul_mcand;
    pidsl_mul_stat_t             mul_stat;
    logic signed [PROD_W-1:0]    mul_product;
    logic signed [TERM_W:0]      term;
    logic signed [TERM_W+1:0]    integ_sum;
    logic signed [PROD_W-1:0]    f_round;
    logic signed [TERM_W+1:0]    total;
    logic signed [TERM_W-1:0]    biased;
    logic signed [ERR_W-1:0]     drive_wide;

    pidsl_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg),
        .mplr    (mul_mplr),
        .mcand   (mul_mcand),
        .stat    (mul_stat),
        .product (mul_product)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign set_ext   = ERR_W'(in_data.set_speed);
    assign mag       = in_data.set_speed[SPEED_W-1] ? -set_ext : set_ext;
    assign in_dead   = mag < {2'b00, dband_reg};
    assign err_next  = set_ext - ERR_W'(in_data.measured_speed);
    assign diff_next = DIFF_W'(err_next) - DIFF_W'(prev_reg);

    always_comb
    begin
        unique case (state_reg)
            S_MUL_P:
            begin
                mul_mplr  = MPLR_W'(err_reg);
                mul_mcand = MCAND_W'(prop_reg);
            end
            S_MUL_I:
            begin
                mul_mplr  = MPLR_W'(err_reg);
                mul_mcand = MCAND_W'(integ_gain_reg);
            end
            S_MUL_D:
            begin
                mul_mplr  = MPLR_W'(diff_reg);
                mul_mcand = MCAND_W'(deriv_reg);
            end
            S_MUL_F:
            begin
                mul_mplr  = {2'b00, smooth_reg};
                mul_mcand = MCAND_W'(dr_reg) - MCAND_W'(f_reg);
            end
            default:
            begin
                mul_mplr  = '0;
                mul_mcand = '0;
            end
        endcase
    end

    always_comb
    begin
        term       = sat_shl14(mul_product);
        integ_sum  = (TERM_W+2)'(integ_reg) + (TERM_W+2)'(term);
        f_round    = (mul_product + PROD_W'(32768)) >>> 16;
        total      = (TERM_W+2)'(p_reg) + (TERM_W+2)'(integ_reg) + (TERM_W+2)'(f_reg);
        biased     = sum_reg + 32'sd16384;
        drive_wide = ERR_W'(biased >>> 15);

        state_next = state_reg;
        go_next    = 1'b0;
        integ_next = integ_reg;
        prev_next  = prev_reg;
        f_next     = f_reg;
        held_next  = held_reg;
        p_next     = p_reg;
        dr_next    = dr_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    prev_next = err_next;
                    if (in_dead)
                    begin
                        integ_next           = '0;
                        res_next.drive       = held_reg;
                        res_next.in_deadband = 1'b1;
                        state_next           = S_DONE;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = S_MUL_P;
                    end
                end
            end
            S_MUL_P:
            begin
                if (mul_stat.done)
                begin
                    p_next     = sat32(term);
                    go_next    = 1'b1;
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                if (mul_stat.done)
                begin
                    integ_next = clamp_q30(integ_sum);
                    go_next    = 1'b1;
                    state_next = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                if (mul_stat.done)
                begin
                    dr_next    = sat32(term);
                    go_next    = 1'b1;
                    state_next = S_MUL_F;
                end
            end
            S_MUL_F:
            begin
                if (mul_stat.done)
                begin
                    f_next     = f_reg + f_round[TERM_W-1:0];
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next   = clamp_q30(total);
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                if (drive_wide > 17'sd32767)
                begin
                    res_next.drive = 16'sh7FFF;
                end
                else
                begin
                    res_next.drive = drive_wide[DRIVE_W-1:0];
                end
                res_next.in_deadband = 1'b0;
                held_next            = res_next.drive;
                state_next           = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            integ_reg      <= '0;
            prev_reg       <= '0;
            f_reg          <= '0;
            held_reg       <= '0;
            prop_reg       <= '0;
            integ_gain_reg <= '0;
            deriv_reg      <= '0;
            smooth_reg     <= SMOOTH_RESET;
            dband_reg      <= DBAND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            f_reg         <= f_next;
            held_reg      <= held_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:       prop_reg       <= cfg_data;
                    CFG_INTEG_GAIN:      integ_gain_reg <= cfg_data;
                    CFG_DERIV_GAIN:      deriv_reg      <= cfg_data;
                    CFG_DERIV_SMOOTHING: smooth_reg     <= cfg_data[SMOOTH_W-1:0];
                    CFG_DEADBAND:        dband_reg      <= cfg_data[DBAND_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        p_reg        <= p_next;
        dr_reg       <= dr_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg <= ONE_Q30 && integ_reg >= -ONE_Q30)
        else $error("integral left its clamp range");

    a_dead_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_dead |=> integ_reg == '0)
        else $error("deadband beat did not clear the integral");

    a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !res_reg.in_deadband |-> res_reg.drive == held_reg)
        else $error("held drive differs from the pending result");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> state_reg == S_MUL_P || state_reg == S_MUL_I
                          || state_reg == S_MUL_D || state_reg == S_MUL_F)
        else $error("multiplier finished outside a product step");

endmodule

`default_nettype wire

/* sv/pidsl_mul.sv */
// Bit-serial signed multiplier, one multiplier bit per cycle, most significant bit first.
`default_nettype none

module pidsl_mul
    import pidsl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [MPLR_W-1:0]   mplr,
    input  wire logic signed [MCAND_W-1:0]  mcand,
    output pidsl_mul_stat_t                 stat,
    output logic signed [PROD_W-1:0]        product
);

    localparam int CNT_W = $clog2(MPLR_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPLR_W - 1);

    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]  acc_next;
    logic signed [MPLR_W-1:0]  mplr_reg;
    logic signed [MCAND_W-1:0] mcand_reg;
    logic signed [PROD_W-1:0]  addend;

    // The leading multiplier bit carries negative weight in two's complement.
    always_comb
    begin
        addend = '0;
        if (mplr_reg[MPLR_W-1])
        begin
            if (cnt_reg == '0)
            begin
                addend = -PROD_W'(mcand_reg);
            end
            else
            begin
                addend = PROD_W'(mcand_reg);
            end
        end
        acc_next  = {acc_reg[PROD_W-2:0], 1'b0} + addend;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mplr_reg  <= mplr;
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            mplr_reg <= {mplr_reg[MPLR_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == CNT_LAST |=> done_reg && !busy_reg)
        else $error("multiplier failed to finish after its last step");

endmodule

`default_nettype wire
